// File: hdl/windowed_positive_average_assert.svh
// Assertion macros for the windowed positive average block.
// Included by the top level; needs no package.
`ifndef WINDOWED_POSITIVE_AVERAGE_ASSERT_SVH
`define WINDOWED_POSITIVE_AVERAGE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WPA_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define WPA_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: hdl/wpa_pkg.sv
// Shared types and fixed constants of the windowed positive average block.
// No dependencies.
`default_nettype none

package wpa_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAG_W       = SAMPLE_W - 1;
   localparam int MAG_MAX     = (1 << MAG_W) - 1;
   localparam int FRAC_W      = 8;
   localparam int AVG_W       = 23;
   localparam int COUNT_W     = 8;
   localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [MAG_W-1:0]           mag_type;
   typedef logic [AVG_W-1:0]           avg_type;
   typedef logic [COUNT_W-1:0]         count_type;

   // Head of the request queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      mag_type magnitude;
   } wpa_item_type;

   // Divider status toward the back end.
   typedef struct packed {
      logic busy;
      logic done;
   } wpa_div_status_type;

endpackage

`default_nettype wire

// File: hdl/wpa_channels.sv
// Valid/ready channel interfaces for request and response.
// Depends on wpa_pkg.
`default_nettype none

interface wpa_req_if;
   logic                valid;
   logic                ready;
   wpa_pkg::sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface wpa_rsp_if;
   logic               valid;
   logic               ready;
   wpa_pkg::avg_type   average;
   wpa_pkg::count_type positive_count;

   modport source (output valid, output average, output positive_count, input ready);
   modport sink   (input valid, input average, input positive_count, output ready);
endinterface

`default_nettype wire

// File: hdl/wpa_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module wpa_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 240
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hdl/wpa_front.sv
// Front end: accepts requests, keeps the positive part, queues it.
// Depends on wpa_pkg and wpa_channels.
`default_nettype none

module wpa_front (
   input  wire logic          clock,
   input  wire logic          reset,
   wpa_req_if.sink            req,
   input  wire logic          head_pop,
   output wpa_pkg::wpa_item_type head
);

   localparam int QPTR_W  = (wpa_pkg::QUEUE_DEPTH > 1) ? $clog2(wpa_pkg::QUEUE_DEPTH) : 1;
   localparam int QFILL_W = $clog2(wpa_pkg::QUEUE_DEPTH + 1);

   wpa_pkg::mag_type    data_ff [wpa_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]  fill_ff, fill_in;
   logic                push;
   wpa_pkg::mag_type    magnitude;

   // Zero and negative samples carry no weight: store them as zero.
   assign magnitude = req.sample[wpa_pkg::SAMPLE_W-1] ? '0
                                                      : req.sample[wpa_pkg::MAG_W-1:0];

   assign req.ready = (fill_ff != QFILL_W'(wpa_pkg::QUEUE_DEPTH));
   assign push      = req.valid && req.ready;

   assign head.valid     = (fill_ff != '0);
   assign head.magnitude = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(wpa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(wpa_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_ff + 1'b1;
      end
      case ({push, head_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= magnitude;
      end
   end

endmodule

`default_nettype wire

// File: hdl/wpa_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on wpa_pkg.
`default_nettype none

module wpa_div #(
   parameter int DIVIDEND_W = 31,
   parameter int DIVISOR_W  = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output wpa_pkg::wpa_div_status_type status,
   output logic      [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] work_ff, work_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // Shift the next dividend bit into the partial remainder.
   assign trial = {rem_ff, work_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(DIVIDEND_W);
         work_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         work_in  = {work_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = work_ff;

endmodule

`default_nettype wire

// File: hdl/wpa_back.sv
// Back end: ring update, running sum and tally, divide, response register.
// Depends on wpa_pkg, wpa_channels, wpa_ram and wpa_div.
`default_nettype none

module wpa_back #(
   parameter int WINDOW = 240
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wpa_pkg::wpa_item_type  head,
   output logic                   head_pop,
   wpa_rsp_if.source              rsp
);

   localparam int PTR_W   = $clog2(WINDOW);
   localparam int TALLY_W = $clog2(WINDOW + 1);
   localparam int SUM_W   = $clog2(WINDOW * wpa_pkg::MAG_MAX + 1);
   localparam int DIV_W   = SUM_W + wpa_pkg::FRAC_W;
   localparam int WIDE_W  = TALLY_W + wpa_pkg::COUNT_W;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_UPDATE  = 4'b0010,
      ST_DIVIDE  = 4'b0100,
      ST_DELIVER = 4'b1000
   } back_state_type;

   back_state_type             state_ff, state_in;
   logic [PTR_W-1:0]           ptr_ff, ptr_in;
   logic                       wrapped_ff, wrapped_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [TALLY_W-1:0]         tally_ff, tally_in;
   wpa_pkg::mag_type           mag_ff, mag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   wpa_pkg::avg_type           avg_ff, avg_in;
   wpa_pkg::count_type         cnt_ff, cnt_in;

   logic                       ram_we;
   logic                       ram_re;
   wpa_pkg::mag_type           ram_rdata;
   wpa_pkg::mag_type           leaving;
   logic                       div_start;
   wpa_pkg::wpa_div_status_type div_status;
   logic [DIV_W-1:0]           div_quotient;
   logic [WIDE_W-1:0]          tally_wide;

   wpa_ram #(
      .WIDTH (wpa_pkg::MAG_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ptr_ff),
      .wdata (mag_ff),
      .rdata (ram_rdata)
   );

   wpa_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (TALLY_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_in, {wpa_pkg::FRAC_W{1'b0}}}),
      .divisor  (tally_in),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Entries not yet written since reset read as zero until the first wrap.
   assign leaving    = wrapped_ff ? ram_rdata : '0;
   assign tally_wide = {{wpa_pkg::COUNT_W{1'b0}}, tally_ff};

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      wrapped_in   = wrapped_ff;
      sum_in       = sum_ff;
      tally_in     = tally_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      avg_in       = avg_ff;
      cnt_in       = cnt_ff;
      head_pop     = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               ram_re   = 1'b1;
               mag_in   = head.magnitude;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ram_we    = 1'b1;
            sum_in    = sum_ff - SUM_W'(leaving) + SUM_W'(mag_ff);
            tally_in  = tally_ff - TALLY_W'(leaving != '0) + TALLY_W'(mag_ff != '0);
            div_start = 1'b1;
            if (ptr_ff == PTR_W'(WINDOW - 1)) begin
               ptr_in     = '0;
               wrapped_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               avg_in       = (tally_ff == '0) ? '0 : div_quotient[wpa_pkg::AVG_W-1:0];
               cnt_in       = (tally_wide > WIDE_W'(wpa_pkg::COUNT_MAX))
                              ? wpa_pkg::count_type'(wpa_pkg::COUNT_MAX)
                              : tally_wide[wpa_pkg::COUNT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         wrapped_ff   <= 1'b0;
         sum_ff       <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         wrapped_ff   <= wrapped_in;
         sum_ff       <= sum_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      avg_ff <= avg_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.average        = avg_ff;
   assign rsp.positive_count = cnt_ff;

endmodule

`default_nettype wire

// File: hdl/windowed_positive_average.sv
// Windowed positive average: mean of the positive samples in a sliding window.
// Depends on wpa_pkg, wpa_channels, wpa_front, wpa_back and the assertion header.
//
// Usage:
//   req_chan carries one signed 16-bit sample per request; rsp_chan returns
//   exactly one response per request, in order: the floor mean of the
//   strictly positive samples among the last WINDOW requests (unsigned,
//   8 fraction bits, 0 when none) and their count, saturated at 255.
//   Both channels are valid/ready; a request or response moves on a clock
//   edge with valid and ready high.
//   The back end works on one request at a time; its pace is set by the
//   bit-serial divider that produces one quotient bit per cycle while busy
//   over SUM_W + 8 bits (SUM_W = clog2(WINDOW * 32767 + 1)).
//   A two-entry request queue lets the front keep accepting while the back
//   divides; the response register lets the back start the next request
//   while a response waits. When rsp_chan stalls, the back holds its
//   finished result, the queue fills, and req_chan.ready drops.
//   Reset (synchronous, active high) empties the queue, zeroes the sum,
//   tally and ring pointer; ring entries not yet written read as zero until
//   the pointer first wraps, so no clearing pass is needed.
`default_nettype none

`include "windowed_positive_average_assert.svh"

module windowed_positive_average #(
   parameter int WINDOW = 240
) (
   input wire logic  clock,
   input wire logic  reset,
   wpa_req_if.sink   req_chan,
   wpa_rsp_if.source rsp_chan
);

   wpa_pkg::wpa_item_type head_item;
   logic                  head_pop;

   // Accept and classify requests, then queue them.
   wpa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .head_pop (head_pop),
      .head     (head_item)
   );

   // Update the window, divide, and hold the response.
   wpa_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head_item),
      .head_pop (head_pop),
      .rsp      (rsp_chan)
   );

   // The back end must never pop an empty queue.
   `WPA_ASSERT_IMPLY(a_pop_needs_item, clock, reset, head_pop, head_item.valid, "pop of empty queue")

   // An accepted request that is not popped leaves an item queued.
   `WPA_ASSERT_NEXT(a_accept_fills, clock, reset, req_chan.valid && req_chan.ready && !head_pop, head_item.valid, "accepted request lost")

   // A full queue always presents an item to the back end.
   `WPA_ASSERT_IMPLY(a_full_has_head, clock, reset, !req_chan.ready, head_item.valid, "full queue shows no item")

   // A zero average goes with a zero count and only then, since sum >= tally.
   `WPA_ASSERT_IMPLY(a_avg_count_agree, clock, reset, rsp_chan.valid, (rsp_chan.positive_count == '0) == (rsp_chan.average == '0), "average and count disagree")

endmodule

`default_nettype wire
